### hw/rtl/aprs_pkg.sv
// Shared constants and types for the APRS packet type classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package aprs_pkg;

    localparam int MAX_PACKET_LEN = 256;
    localparam int POS_W          = $clog2(MAX_PACKET_LEN);
    localparam int MASK_W         = 10;
    localparam int OUT_DATA_W     = 16;

    // Class mask bits
    localparam logic [MASK_W-1:0] M_POS   = 10'h001;
    localparam logic [MASK_W-1:0] M_COMP  = 10'h002;
    localparam logic [MASK_W-1:0] M_WX    = 10'h004;
    localparam logic [MASK_W-1:0] M_TLM   = 10'h008;
    localparam logic [MASK_W-1:0] M_MSG   = 10'h010;
    localparam logic [MASK_W-1:0] M_STAT  = 10'h020;
    localparam logic [MASK_W-1:0] M_QRY   = 10'h040;
    localparam logic [MASK_W-1:0] M_OBJ   = 10'h080;
    localparam logic [MASK_W-1:0] M_ITEM  = 10'h100;
    localparam logic [MASK_W-1:0] M_THIRD = 10'h200;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_P   = 8'h50;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_LO_G   = 8'h67;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Request from the top level to the segment tracker
    typedef struct packed {
        logic       take;
        logic [7:0] data;
        logic       flush;
    } seg_cmd_t;

    // Segment tracker status back to the top level
    typedef struct packed {
        logic              split;
        logic [MASK_W-1:0] flags;
    } seg_status_t;

endpackage

### hw/rtl/aprs_segment.sv
// Segment tracker: per-segment state and classification of one byte per cycle while take is set.
// Depends on aprs_pkg.
`timescale 1ns / 1ps

module aprs_segment
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  aprs_pkg::seg_cmd_t    cmd,
    output aprs_pkg::seg_status_t status
);
    import aprs_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [7:0]        type_char;
        logic [MASK_W-1:0] flags;
        logic [3:0]        letters;
        logic [3:0]        kw;
        logic              colon9;
        logic              await_colon;
    } seg_state_t;

    localparam seg_state_t SEG_RESET = '{
        pos: '0, type_char: 8'h00, flags: '0, letters: 4'h0,
        kw: 4'hF, colon9: 1'b0, await_colon: 1'b0
    };
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_LEN - 1);

    // Keyword letters, row per keyword: PARM, UNIT, EQNS, BITS
    localparam logic [7:0] KW_TAB [4][4] = '{
        '{8'h50, 8'h41, 8'h52, 8'h4D},
        '{8'h55, 8'h4E, 8'h49, 8'h54},
        '{8'h45, 8'h51, 8'h4E, 8'h53},
        '{8'h42, 8'h49, 8'h54, 8'h53}
    };

    function automatic logic [MASK_W-1:0] flags_of_type(input logic [7:0] c);
        logic [MASK_W-1:0] f;
        begin
            unique case (c) inside
                CH_DOLLAR:                         f = M_POS;
                CH_SQUOTE, CH_BQUOTE:              f = M_POS | M_COMP;
                CH_BANG, CH_EQ, CH_SLASH, CH_AT:   f = M_POS;
                CH_LBRACE, CH_LT, CH_GT:           f = M_STAT;
                CH_QUERY:                          f = M_QRY;
                CH_SEMI:                           f = M_OBJ;
                CH_RPAREN:                         f = M_ITEM;
                CH_RBRACE:                         f = M_THIRD;
                CH_UP_T:                           f = M_TLM;
                CH_HASH, CH_STAR, CH_UNDER:        f = M_WX;
                default:                           f = '0;
            endcase
            return f;
        end
    endfunction

    function automatic logic seg_is_pos(input logic [7:0] c);
        return (c == CH_BANG) || (c == CH_EQ) || (c == CH_SLASH) || (c == CH_AT);
    endfunction

    function automatic logic [MASK_W-1:0] seg_result(input seg_state_t s);
        logic [MASK_W-1:0] f;
        begin
            f = s.flags;
            if (seg_is_pos(s.type_char) && (s.letters == 4'hF))
                f = f | M_WX;
            if (s.type_char == CH_COLON)
            begin
                if (s.colon9 && (s.kw != 4'h0) && (s.pos >= POS_W'(15)))
                    f = f | M_TLM;
                else
                    f = f | M_MSG;
            end
            if (s.pos == '0)
                f = '0;
            return f;
        end
    endfunction

    seg_state_t       seg_reg;
    seg_state_t       seg_next;
    seg_state_t       seg_upd;
    logic             split;
    logic [POS_W-1:0] p;
    logic [7:0]       c;
    logic [7:0]       b;
    logic [1:0]       kw_idx;

    always_comb
    begin
        p       = seg_reg.pos;
        c       = seg_reg.type_char;
        b       = cmd.data;
        kw_idx  = 2'(p - POS_W'(11));
        seg_upd = seg_reg;
        split   = 1'b0;

        if (cmd.take)
        begin
            if (p == '0)
            begin
                seg_upd.type_char   = b;
                seg_upd.flags       = flags_of_type(b);
                seg_upd.await_colon = (b == CH_RBRACE);
            end
            else if (seg_reg.await_colon && (b == CH_COLON))
            begin
                // third-party header ends here; inner segment starts next byte
                split = 1'b1;
            end
            else
            begin
                if (b == CH_LO_R) seg_upd.letters[0] = 1'b1;
                if (b == CH_LO_G) seg_upd.letters[1] = 1'b1;
                if (b == CH_LO_T) seg_upd.letters[2] = 1'b1;
                if (b == CH_UP_P) seg_upd.letters[3] = 1'b1;

                if (b == CH_UNDER)
                begin
                    if (((c == CH_BANG) || (c == CH_EQ)) &&
                        ((p == POS_W'(11)) || (p == POS_W'(17)) ||
                         (p == POS_W'(19)) || (p == POS_W'(26))))
                        seg_upd.flags = seg_upd.flags | M_WX;
                    if (((c == CH_SLASH) || (c == CH_AT)) &&
                        ((p == POS_W'(17)) || (p == POS_W'(26))))
                        seg_upd.flags = seg_upd.flags | M_WX;
                    if ((c == CH_SEMI) && (p == POS_W'(36)))
                        seg_upd.flags = seg_upd.flags | M_WX;
                end

                if (c == CH_COLON)
                begin
                    if ((p == POS_W'(10)) && (b == CH_COLON))
                        seg_upd.colon9 = 1'b1;
                    if ((p >= POS_W'(11)) && (p <= POS_W'(14)))
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            if (KW_TAB[j][kw_idx] != b)
                                seg_upd.kw[j] = 1'b0;
                        end
                    end
                end
            end

            // saturate past every checked offset
            if (!split && (p != POS_MAX))
                seg_upd.pos = p + POS_W'(1);
        end

        status.split = split;
        status.flags = split ? seg_result(seg_reg) : seg_result(seg_upd);
        seg_next     = (split || cmd.flush) ? SEG_RESET : seg_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= SEG_RESET;
        else
            seg_reg <= seg_next;
    end

endmodule

### hw/rtl/aprs_packet_type_classifier.sv
// APRS packet type classifier, top level: stream ports, input and result registers.
// Result path: the last byte passes the input register, then its class mask is captured in the result register.
// Throughput: one byte per cycle; the input register drains every cycle unless a
// last byte meets a result still waiting downstream.
// Reset: rst_n asynchronous, active low; clears all segment state and empties both registers.
// Depends on aprs_pkg and aprs_segment.
`timescale 1ns / 1ps

module aprs_packet_type_classifier
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] packet_byte
    input  logic                            s_axis_tlast,  // last_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [aprs_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [9:0] class_mask, [15:10] zero
);
    import aprs_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              ended_reg;
    logic              ended_next;
    logic [MASK_W-1:0] outer_reg;
    logic [MASK_W-1:0] outer_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MASK_W-1:0] out_mask_reg;
    logic              in_accept;
    logic              proceed;
    logic              finish;
    logic [MASK_W-1:0] combined;
    seg_cmd_t          cmd;
    seg_status_t       status;

    // a last byte waits only while the result register is full and stalled
    assign proceed   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign finish    = proceed && in_last_reg;
    assign s_axis_tready = !in_valid_reg || proceed;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign cmd.take  = proceed && !ended_reg && (in_byte_reg != CH_NUL);
    assign cmd.data  = in_byte_reg;
    assign cmd.flush = finish;

    aprs_segment u_segment
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    assign combined = outer_reg | status.flags;

    always_comb
    begin
        in_valid_next = in_accept ? 1'b1 : (proceed ? 1'b0 : in_valid_reg);

        outer_next = outer_reg;
        if (finish)
            outer_next = '0;
        else if (status.split)
            outer_next = combined;

        ended_next = ended_reg;
        if (finish)
            ended_next = 1'b0;
        else if (proceed && (in_byte_reg == CH_NUL))
            ended_next = 1'b1;

        out_valid_next = finish ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            ended_reg     <= 1'b0;
            outer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            ended_reg     <= ended_next;
            outer_reg     <= outer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (finish)
            out_mask_reg <= combined;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - MASK_W)'(0), out_mask_reg};

endmodule

### hw/rtl/aprs_checker.sv
// Port-level checks for the APRS packet type classifier, bound to the top level.
// Depends on aprs_pkg and aprs_packet_type_classifier.
`timescale 1ns / 1ps

module aprs_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [aprs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import aprs_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a new result follows an accepted last-byte request, with the input and result registers between them
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a last-byte request");

    // compressed type always carries position
    a_comp_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
        else $error("compressed flag without position flag");

    // with the result side empty, the input never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

bind aprs_packet_type_classifier aprs_checker u_aprs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
